@@ hdl/scnl_pkg.sv @@
package scnl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int VALUE_BITS  = 16;

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [VALUE_BITS:0]   t_val_ext;

    // Separator codes carried with every token.
    localparam logic [1:0] FOLLOW_NONE  = 2'd0;
    localparam logic [1:0] FOLLOW_COMMA = 2'd1;
    localparam logic [1:0] FOLLOW_DASH  = 2'd2;

    // Broadcast control to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // The three cells at the head of the chain, seen by the condenser.
    typedef struct packed {
        t_val val0;
        t_val val1;
        t_val val2;
        logic valid0;
        logic valid1;
        logic valid2;
    } t_head;

endpackage

@@ hdl/scnl_cell.sv @@
module scnl_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scnl_pkg::t_cell_ctrl i_ctrl,
    input  scnl_pkg::t_val       i_x,
    input  scnl_pkg::t_val       i_prev_val,
    input  logic                 i_prev_valid,
    input  logic                 i_prev_greater,
    input  scnl_pkg::t_val       i_next_val,
    input  logic                 i_next_valid,
    output scnl_pkg::t_val       o_val,
    output logic                 o_valid,
    output logic                 o_greater
);
    import scnl_pkg::*;

    t_val r_val;
    t_val n_val;
    logic r_valid;
    logic n_valid;

    assign o_greater = r_valid && (r_val > i_x);
    assign o_val     = r_val;
    assign o_valid   = r_valid;

    // On insert, every cell holding a larger value moves one place up, and the
    // first cell that is larger (or the first empty one) takes the new number.
    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctrl.insert && (o_greater || (!r_valid && i_prev_valid))) begin
            n_val   = i_prev_greater ? i_prev_val : i_x;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

@@ hdl/scnl_condense.sv @@
module scnl_condense (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_active,
    input  scnl_pkg::t_head i_head,
    input  logic            i_overflow,
    output logic            o_shift,
    output logic            o_done,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [15:0]     o_value,
    output logic [1:0]      o_follow,
    output logic            o_last_token,
    output logic            o_overflow
);
    import scnl_pkg::*;

    logic       r_skip;
    logic       n_skip;
    logic       r_out_valid;
    logic       r_last;
    logic       r_ovf;
    logic [1:0] r_follow;
    t_val       r_value;

    logic       adv;
    logic       inc1;
    logic       inc2;
    logic       emit;
    logic [1:0] follow;

    assign adv  = i_active && (!r_out_valid || i_out_ready);
    assign inc1 = i_head.valid1 &&
                  ({1'b0, i_head.val1} == ({1'b0, i_head.val0} + t_val_ext'(1)));
    assign inc2 = i_head.valid2 &&
                  ({1'b0, i_head.val2} == ({1'b0, i_head.val0} + t_val_ext'(2)));

    // Inside a range the interior values are dropped until the head holds the
    // last value of the run, which then goes out as an ordinary token.
    always_comb begin
        n_skip = r_skip;
        emit   = 1'b1;
        follow = i_head.valid1 ? FOLLOW_COMMA : FOLLOW_NONE;
        if (r_skip) begin
            if (inc1) begin
                emit = 1'b0;
            end else begin
                n_skip = 1'b0;
            end
        end else if (inc1 && inc2) begin
            follow = FOLLOW_DASH;
            n_skip = 1'b1;
        end
    end

    assign o_shift = adv;
    assign o_done  = adv && emit && !i_head.valid1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_skip <= n_skip;
            end
            if (adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_value  <= i_head.val0;
            r_follow <= follow;
            r_last   <= !i_head.valid1;
            r_ovf    <= i_overflow;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = 16'(r_value);
    assign o_follow     = r_follow;
    assign o_last_token = r_last;
    assign o_overflow   = r_ovf;

endmodule

@@ hdl/sort_and_condense_number_list_core.sv @@
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_ref_number, i_is_last
// output    o_out_valid / i_out_ready  o_value, o_follow, o_last_token, o_overflow
//
// Numbers are inserted into a sorted chain of cells at one item per cycle while collecting.
// After the marked item the chain shifts toward its head one place per cycle whenever
// the output is not stalled, and the list is emitted from the head of the chain.
// No item is accepted while a list is being emitted; the next list may start in the
// cycle after the final token is loaded into the output register.
// Reset is synchronous and active low and empties the chain.
module sort_and_condense_number_list_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_ref_number,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_value,
    output logic [1:0]  o_follow,
    output logic        o_last_token,
    output logic        o_overflow
);
    import scnl_pkg::*;

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ovf;
    logic   n_ovf;

    t_cell_ctrl             ctrl;
    t_head                  head;
    t_val                   x;
    t_val                   cell_val     [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_valid;
    logic [MAX_ENTRIES-1:0] cell_greater;
    logic                   accept;
    logic                   full;
    logic                   shift;
    logic                   done;

    assign x          = t_val'(i_ref_number);
    assign o_in_ready = (r_state == ST_COLLECT);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = cell_valid[MAX_ENTRIES-1];

    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = shift;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        t_val prev_val;
        logic prev_valid;
        logic prev_greater;
        t_val next_val;
        logic next_valid;

        if (k == 0) begin : g_first
            assign prev_val     = '0;
            assign prev_valid   = 1'b1;
            assign prev_greater = 1'b0;
        end else begin : g_mid
            assign prev_val     = cell_val[k-1];
            assign prev_valid   = cell_valid[k-1];
            assign prev_greater = cell_greater[k-1];
        end

        if (k == MAX_ENTRIES - 1) begin : g_last
            assign next_val   = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_val   = cell_val[k+1];
            assign next_valid = cell_valid[k+1];
        end

        scnl_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (ctrl),
            .i_x            (x),
            .i_prev_val     (prev_val),
            .i_prev_valid   (prev_valid),
            .i_prev_greater (prev_greater),
            .i_next_val     (next_val),
            .i_next_valid   (next_valid),
            .o_val          (cell_val[k]),
            .o_valid        (cell_valid[k]),
            .o_greater      (cell_greater[k])
        );
    end

    assign head.val0   = cell_val[0];
    assign head.val1   = cell_val[1];
    assign head.val2   = cell_val[2];
    assign head.valid0 = cell_valid[0];
    assign head.valid1 = cell_valid[1];
    assign head.valid2 = cell_valid[2];

    scnl_condense u_condense (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_active     (r_state == ST_EMIT),
        .i_head       (head),
        .i_overflow   (r_ovf),
        .o_shift      (shift),
        .o_done       (done),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_follow     (o_follow),
        .o_last_token (o_last_token),
        .o_overflow   (o_overflow)
    );

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        case (r_state)
            ST_COLLECT: begin
                if (accept) begin
                    n_ovf = r_ovf || full;
                    if (i_is_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (done) begin
                    n_state = ST_COLLECT;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_COLLECT;
                n_ovf   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

`ifndef ASSERT_OFF
    // The stored entries always occupy a contiguous run of cells from the head.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_valid & (cell_valid + MAX_ENTRIES'(1))) == '0)
        else $error("chain valid bits are not a prefix");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> cell_valid[0])
        else $error("emitting from an empty chain");

    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (cell_valid == '0))
        else $error("chain not empty after final token");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full) |=> r_ovf)
        else $error("dropped item did not set overflow");
`endif

endmodule
